FILE: rtl/hpq_pkg.sv
package hpq_pkg;

    // Fixed field widths
    localparam int unsigned EVT_TIME_W = 48;
    localparam int unsigned PERIOD_W   = 32;
    localparam int unsigned COUNT_W    = 8;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 32;

    // Event kinds
    localparam logic CMD_EDGE = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PERIOD    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PERIOD    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_STALL_TIMEOUT = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_LIMIT   = CFG_IDX_W'(3);

    // Register reset values
    localparam logic [PERIOD_W-1:0] RST_MIN_PERIOD    = 32'd25000000;
    localparam logic [PERIOD_W-1:0] RST_MAX_PERIOD    = 32'd70000000;
    localparam logic [PERIOD_W-1:0] RST_STALL_TIMEOUT = 32'd500000000;
    localparam logic [COUNT_W-1:0]  RST_COUNT_LIMIT   = 8'd10;

    typedef struct packed {
        logic                  cmd;
        logic [EVT_TIME_W-1:0] event_time;
    } t_evt_item;

    typedef struct packed {
        logic                sync_valid;
        logic [PERIOD_W-1:0] period;
        logic [COUNT_W-1:0]  stable_count;
        logic                read_reply;
    } t_res_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_item;

    typedef struct packed {
        logic [PERIOD_W-1:0] min_period;
        logic [PERIOD_W-1:0] max_period;
        logic [PERIOD_W-1:0] stall_timeout;
        logic [COUNT_W-1:0]  count_limit;
    } t_cfg_regs;

endpackage

FILE: rtl/hpq_stream_if.sv
// Valid/ready channel carrying one item of type T
interface hpq_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/hall_period_qualifier.sv
// Hall sensor period qualifier. Each event item is a rising sensor edge
// (cmd 0) or a status read (cmd 1) with a free-running nanosecond timestamp;
// only its low TIME_WIDTH bits are used and elapsed time wraps modulo
// 2^TIME_WIDTH. Edges closer than min_period to the last accepted edge are
// dropped as noise; slower than max_period they decrement the stability
// count, otherwise they increment it up to count_limit and report sync with
// the measured period. A read clears the count after stall_timeout ns with
// no accepted edge. Every event gives exactly one result item. The block
// takes one item per clock while o_res.ready does not stall the result register:
// an input register, then the combinational subtract/compare/count update
// into the result register. Configuration writes are always ready and
// must only be made while no item is in flight.
module hall_period_qualifier #(
    parameter int unsigned TIME_WIDTH = 48
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hpq_stream_if.sink   i_evt,
    hpq_stream_if.source o_res,
    hpq_stream_if.sink   i_cfg
);
    import hpq_pkg::*;

    t_cfg_regs regs;
    t_res_item res_next;

    logic      r_in_valid;
    t_evt_item r_in_item;
    logic      r_out_valid;
    t_res_item r_out_item;
    logic      advance;

    hpq_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_regs  (regs)
    );

    // Move the held item on when the result register is free or draining
    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_evt.ready = !r_in_valid || advance;

    hpq_qualifier #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_qual (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_regs  (regs),
        .i_item  (r_in_item),
        .i_fire  (advance),
        .o_res   (res_next)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_evt.ready) begin
            r_in_valid <= i_evt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_evt.valid && i_evt.ready) begin
            r_in_item <= i_evt.data;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= res_next;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out_item;

endmodule

FILE: rtl/hpq_cfg_regs.sv
module hpq_cfg_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    hpq_stream_if.sink         i_cfg,
    output hpq_pkg::t_cfg_regs o_regs
);
    import hpq_pkg::*;

    t_cfg_regs r_regs;
    t_cfg_regs n_regs;

    // Writes are always taken; unknown indexes are dropped
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_regs = r_regs;
        if (i_cfg.valid) begin
            unique case (i_cfg.data.index)
                REG_MIN_PERIOD:    n_regs.min_period    = i_cfg.data.data;
                REG_MAX_PERIOD:    n_regs.max_period    = i_cfg.data.data;
                REG_STALL_TIMEOUT: n_regs.stall_timeout = i_cfg.data.data;
                REG_COUNT_LIMIT:   n_regs.count_limit   = i_cfg.data.data[COUNT_W-1:0];
                default:           n_regs = r_regs;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs.min_period    <= RST_MIN_PERIOD;
            r_regs.max_period    <= RST_MAX_PERIOD;
            r_regs.stall_timeout <= RST_STALL_TIMEOUT;
            r_regs.count_limit   <= RST_COUNT_LIMIT;
        end else begin
            r_regs <= n_regs;
        end
    end

    assign o_regs = r_regs;

endmodule

FILE: rtl/hpq_qualifier.sv
module hpq_qualifier #(
    parameter int unsigned TIME_WIDTH = 48
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hpq_pkg::t_cfg_regs i_regs,
    input  hpq_pkg::t_evt_item i_item,
    input  logic               i_fire,
    output hpq_pkg::t_res_item o_res
);
    import hpq_pkg::*;

    logic [TIME_WIDTH-1:0] r_last_edge;
    logic [TIME_WIDTH-1:0] n_last_edge;
    logic [COUNT_W-1:0]    r_count;
    logic [COUNT_W-1:0]    n_count;

    logic [TIME_WIDTH-1:0] now;
    logic [TIME_WIDTH-1:0] dt;
    logic                  dt_ge_min;
    logic                  dt_gt_max;
    logic                  dt_gt_timeout;

    // Elapsed time, modulo the time width
    assign now           = TIME_WIDTH'(i_item.event_time);
    assign dt            = now - r_last_edge;
    assign dt_ge_min     = dt >= TIME_WIDTH'(i_regs.min_period);
    assign dt_gt_max     = dt >  TIME_WIDTH'(i_regs.max_period);
    assign dt_gt_timeout = dt >  TIME_WIDTH'(i_regs.stall_timeout);

    // Next state and result for the item in hand
    always_comb begin
        n_last_edge        = r_last_edge;
        n_count            = r_count;
        o_res.sync_valid   = 1'b0;
        o_res.period       = '0;
        o_res.read_reply   = 1'b0;
        unique case (i_item.cmd)
            CMD_READ: begin
                o_res.read_reply = 1'b1;
                if (dt_gt_timeout) begin
                    n_count = '0;
                end
            end
            CMD_EDGE: begin
                if (dt_ge_min) begin
                    n_last_edge = now;
                    if (dt_gt_max) begin
                        if (r_count != '0) begin
                            n_count = r_count - COUNT_W'(1);
                        end
                    end else begin
                        // count above a lowered limit is left as is
                        if (r_count < i_regs.count_limit) begin
                            n_count = r_count + COUNT_W'(1);
                        end
                        o_res.sync_valid = 1'b1;
                        o_res.period     = dt[PERIOD_W-1:0];
                    end
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
        o_res.stable_count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_edge <= '0;
            r_count     <= '0;
        end else if (i_fire) begin
            r_last_edge <= n_last_edge;
            r_count     <= n_count;
        end
    end

endmodule
